### rtl/kwmh_pkg.sv
// kwmh_pkg: shared codes, states and default sizes for the k-way merge heap
// used by k_way_merge_min_heap; depends on nothing

package kwmh_pkg;

    localparam int NUM_LISTS_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int LIST_BITS      = 4;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_REPORT  = 2'd1,
        REQ_ADVANCE = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REP,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_CHK,
        S_DN_RDR,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

### rtl/kwmh_ram.sv
// kwmh_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing

module kwmh_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/k_way_merge_min_heap.sv
// k_way_merge_min_heap: binary min-heap of list heads kept in one ram
// depends on kwmh_pkg and kwmh_ram
//
// channel  dir  tdata (low bit up)                        tuser
// s_axis   in   list_id[3:0] value[35:4] has_next[36]     req_type[1:0]
// m_axis   out  min_value[31:0] min_list[35:32]
//               entries[40:36]                            status[1:0]
//
// one request at a time; the ram read port sets the pace of each heap level
// report reads the root; insert writes the new head in the next free slot and climbs,
// moving each parent it beats down a level until it stops or reaches the root;
// advance loads the root, or the last head on a pop, and sifts it down level by level,
// reading left then right child; last-head pop, empty, full or unknown go straight to done
// tready is high only when idle; a result not taken holds the block in its done state
// reset clears the head count, state and output valid only; ram contents need no clearing

module k_way_merge_min_heap #(
    parameter int NUM_LISTS  = kwmh_pkg::NUM_LISTS_DEF,
    parameter int VALUE_BITS = kwmh_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // list_id, value, has_next, zero pad
    input  logic [1:0]  i_s_axis_tuser,   // req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // min_value, min_list, entries, zero pad
    output logic [1:0]  o_m_axis_tuser    // status
);

    localparam int LB = kwmh_pkg::LIST_BITS;
    localparam int EW = VALUE_BITS + LB;
    localparam int IW = $clog2(NUM_LISTS);
    localparam int CW = $clog2(NUM_LISTS + 1);
    localparam int XW = IW + 2;

    function automatic logic before_f(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic signed [VALUE_BITS-1:0] av;
        logic signed [VALUE_BITS-1:0] bv;
        av = $signed(a[EW-1:LB]);
        bv = $signed(b[EW-1:LB]);
        if (av != bv) begin
            return av < bv;
        end
        return a[LB-1:0] < b[LB-1:0];
    endfunction

    kwmh_pkg::t_state r_state, n_state;
    logic                  r_nxt, n_nxt;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [EW-1:0]         r_x, n_x;
    logic [EW-1:0]         r_best, n_best;
    logic                  r_best_l, n_best_l;
    logic                  r_has_r, n_has_r;
    logic [IW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [1:0]            r_status, n_status;
    logic [31:0]           r_mv, n_mv;
    logic [LB-1:0]         r_ml, n_ml;
    logic                  r_o_valid, n_o_valid;
    logic [47:0]           r_o_data, n_o_data;
    logic [1:0]            r_o_user, n_o_user;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic                  s_accept;
    logic [LB-1:0]         in_lid;
    logic signed [31:0]    in_value;
    logic [VALUE_BITS-1:0] in_val_v;
    logic                  in_nxt;
    logic [XW-1:0]         l_ext;
    logic [XW-1:0]         r_ext;
    logic [IW-1:0]         p_idx;
    logic [XW-1:0]         cnt_ext;

    kwmh_ram #(
        .WIDTH(EW),
        .DEPTH(NUM_LISTS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_we),
        .i_wr_addr(ram_waddr),
        .i_wr_data(ram_wdata),
        .i_rd_en  (ram_re),
        .i_rd_addr(ram_raddr),
        .o_rd_data(ram_rdata)
    );

    assign o_s_axis_tready = (r_state == kwmh_pkg::S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign in_lid          = i_s_axis_tdata[3:0];
    assign in_value        = $signed(i_s_axis_tdata[35:4]);
    assign in_val_v        = VALUE_BITS'(in_value);
    assign in_nxt          = i_s_axis_tdata[36];

    assign l_ext   = XW'({r_idx, 1'b1});
    assign r_ext   = XW'({r_idx, 1'b0}) + XW'(2);
    assign p_idx   = IW'((r_idx - IW'(1)) >> 1);
    assign cnt_ext = XW'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kwmh_pkg::S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
        r_nxt    <= n_nxt;
        r_val    <= n_val;
        r_x      <= n_x;
        r_best   <= n_best;
        r_best_l <= n_best_l;
        r_has_r  <= n_has_r;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_mv     <= n_mv;
        r_ml     <= n_ml;
        r_o_data <= n_o_data;
        r_o_user <= n_o_user;
    end

    always_comb begin
        n_state   = r_state;
        n_nxt     = r_nxt;
        n_val     = r_val;
        n_x       = r_x;
        n_best    = r_best;
        n_best_l  = r_best_l;
        n_has_r   = r_has_r;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_status  = r_status;
        n_mv      = r_mv;
        n_ml      = r_ml;
        n_o_valid = r_o_valid && !i_m_axis_tready;
        n_o_data  = r_o_data;
        n_o_user  = r_o_user;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_x;
        ram_re    = 1'b0;
        ram_raddr = '0;

        unique case (r_state)
            kwmh_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_mv     = '0;
                    n_ml     = '0;
                    n_status = kwmh_pkg::ST_OK;
                    n_nxt    = in_nxt;
                    n_val    = in_val_v;
                    n_idx    = '0;
                    unique case (i_s_axis_tuser)
                        kwmh_pkg::REQ_INSERT: begin
                            if (r_cnt >= CW'(NUM_LISTS)) begin
                                n_status = kwmh_pkg::ST_FULL;
                                n_state  = kwmh_pkg::S_DONE;
                            end else begin
                                n_idx   = r_cnt[IW-1:0];
                                n_cnt   = r_cnt + CW'(1);
                                n_x     = {in_val_v, in_lid};
                                n_state = kwmh_pkg::S_UP_CHK;
                            end
                        end
                        kwmh_pkg::REQ_REPORT: begin
                            if (r_cnt == '0) begin
                                n_status = kwmh_pkg::ST_EMPTY;
                                n_state  = kwmh_pkg::S_DONE;
                            end else begin
                                ram_re  = 1'b1;
                                n_state = kwmh_pkg::S_REP;
                            end
                        end
                        kwmh_pkg::REQ_ADVANCE: begin
                            if (r_cnt == '0) begin
                                n_status = kwmh_pkg::ST_EMPTY;
                                n_state  = kwmh_pkg::S_DONE;
                            end else if (in_nxt) begin
                                ram_re  = 1'b1;
                                n_state = kwmh_pkg::S_DN_LOAD;
                            end else begin
                                n_cnt = r_cnt - CW'(1);
                                if (r_cnt == CW'(1)) begin
                                    n_state = kwmh_pkg::S_DONE;
                                end else begin
                                    ram_re    = 1'b1;
                                    ram_raddr = IW'(r_cnt - CW'(1));
                                    n_state   = kwmh_pkg::S_DN_LOAD;
                                end
                            end
                        end
                        default: begin
                            n_state = kwmh_pkg::S_DONE;
                        end
                    endcase
                end
            end
            kwmh_pkg::S_REP: begin
                n_mv    = 32'($signed(ram_rdata[EW-1:LB]));
                n_ml    = ram_rdata[LB-1:0];
                n_state = kwmh_pkg::S_DONE;
            end
            kwmh_pkg::S_UP_CHK: begin
                if (r_idx == '0) begin
                    ram_we  = 1'b1;
                    n_state = kwmh_pkg::S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = p_idx;
                    n_state   = kwmh_pkg::S_UP_CMP;
                end
            end
            kwmh_pkg::S_UP_CMP: begin
                ram_we = 1'b1;
                if (before_f(r_x, ram_rdata)) begin
                    ram_wdata = ram_rdata;
                    n_idx     = p_idx;
                    n_state   = kwmh_pkg::S_UP_CHK;
                end else begin
                    n_state = kwmh_pkg::S_DONE;
                end
            end
            kwmh_pkg::S_DN_LOAD: begin
                n_x     = r_nxt ? {r_val, ram_rdata[LB-1:0]} : ram_rdata;
                n_state = kwmh_pkg::S_DN_CHK;
            end
            kwmh_pkg::S_DN_CHK: begin
                if (l_ext >= cnt_ext) begin
                    ram_we  = 1'b1;
                    n_state = kwmh_pkg::S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = l_ext[IW-1:0];
                    n_state   = kwmh_pkg::S_DN_RDR;
                end
            end
            kwmh_pkg::S_DN_RDR: begin
                if (before_f(ram_rdata, r_x)) begin
                    n_best   = ram_rdata;
                    n_best_l = 1'b1;
                end else begin
                    n_best   = r_x;
                    n_best_l = 1'b0;
                end
                n_has_r = (r_ext < cnt_ext);
                if (r_ext < cnt_ext) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ext[IW-1:0];
                end
                n_state = kwmh_pkg::S_DN_CMP;
            end
            kwmh_pkg::S_DN_CMP: begin
                ram_we = 1'b1;
                if (r_has_r && before_f(ram_rdata, r_best)) begin
                    ram_wdata = ram_rdata;
                    n_idx     = r_ext[IW-1:0];
                    n_state   = kwmh_pkg::S_DN_CHK;
                end else if (r_best_l) begin
                    ram_wdata = r_best;
                    n_idx     = l_ext[IW-1:0];
                    n_state   = kwmh_pkg::S_DN_CHK;
                end else begin
                    n_state = kwmh_pkg::S_DONE;
                end
            end
            kwmh_pkg::S_DONE: begin
                if (!r_o_valid || i_m_axis_tready) begin
                    n_o_valid = 1'b1;
                    n_o_data  = {7'd0, 5'(r_cnt), r_ml, r_mv};
                    n_o_user  = r_status;
                    n_state   = kwmh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kwmh_pkg::S_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_user;

endmodule

### verif/k_way_merge_min_heap_tb.sv
// k_way_merge_min_heap_tb: stream-level test of the k-way merge heap, with its own heap
// predictor checked result by result against the block, under random bursts and stalls
// depends on kwmh_pkg and the k_way_merge_min_heap rtl

module k_way_merge_min_heap_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_NOP    = 2'd3;
    localparam int         HEAP_DEPTH = kwmh_pkg::NUM_LISTS_DEF;
    localparam int         RX_OPEN    = 0;
    localparam int         RX_HALF    = 1;
    localparam int         RX_SPARSE  = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  list;
        logic [31:0] val;
        logic        more;
    } t_merge_req;

    typedef struct packed {
        logic [31:0] min_val;
        logic [3:0]  min_list;
        logic [1:0]  status;
        logic [4:0]  entries;
    } t_merge_res;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata  = '0;  // list_id, value, has_next, zero pad
    logic [1:0]  i_s_axis_tuser  = '0;  // req_type
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;        // min_value, min_list, entries, zero pad
    logic [1:0]  o_m_axis_tuser;        // status

    k_way_merge_min_heap dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_merge_req         req_q[$];
    t_merge_res         want_q[$];
    logic signed [31:0] heap_val [HEAP_DEPTH];
    logic [3:0]         heap_lst [HEAP_DEPTH];
    int                 heap_cnt   = 0;
    int                 gen_cnt    = 0;
    int                 queued     = 0;
    int                 mismatches = 0;
    int                 burst_left = 0;
    int                 gap_left   = 0;
    int                 rx_tick    = 0;
    int                 rx_left    = 0;
    int                 rx_mode    = RX_OPEN;
    bit                 took       = 1'b0;
    t_merge_res         got;
    t_merge_res         want;

    // heap order: smaller value first, lower list number on ties
    function automatic bit ahead(int a, int b);
        if (heap_val[a] != heap_val[b])
            return heap_val[a] < heap_val[b];
        return heap_lst[a] < heap_lst[b];
    endfunction

    function automatic void swap_heads(int a, int b);
        logic signed [31:0] v;
        logic [3:0]         l;
        v = heap_val[a];
        l = heap_lst[a];
        heap_val[a] = heap_val[b];
        heap_lst[a] = heap_lst[b];
        heap_val[b] = v;
        heap_lst[b] = l;
    endfunction

    function automatic void sift_top_down();
        int i;
        int l;
        int best;
        bit done;
        i = 0;
        done = 1'b0;
        while (!done) begin
            l = 2 * i + 1;
            best = i;
            if (l < heap_cnt && ahead(l, best))
                best = l;
            if (l + 1 < heap_cnt && ahead(l + 1, best))
                best = l + 1;
            if (best == i) begin
                done = 1'b1;
            end else begin
                swap_heads(i, best);
                i = best;
            end
        end
    endfunction

    function automatic t_merge_res merge_apply(t_merge_req rq);
        t_merge_res rs;
        int         i;
        rs = '0;
        rs.status = kwmh_pkg::ST_OK;
        case (rq.kind)
            kwmh_pkg::REQ_INSERT: begin
                if (heap_cnt >= HEAP_DEPTH) begin
                    rs.status = kwmh_pkg::ST_FULL;
                end else begin
                    heap_val[heap_cnt] = rq.val;
                    heap_lst[heap_cnt] = rq.list;
                    i = heap_cnt;
                    heap_cnt++;
                    while (i > 0 && ahead(i, (i - 1) / 2)) begin
                        swap_heads(i, (i - 1) / 2);
                        i = (i - 1) / 2;
                    end
                end
            end
            kwmh_pkg::REQ_REPORT: begin
                if (heap_cnt == 0) begin
                    rs.status = kwmh_pkg::ST_EMPTY;
                end else begin
                    rs.min_val  = heap_val[0];
                    rs.min_list = heap_lst[0];
                end
            end
            kwmh_pkg::REQ_ADVANCE: begin
                if (heap_cnt == 0) begin
                    rs.status = kwmh_pkg::ST_EMPTY;
                end else if (rq.more) begin
                    heap_val[0] = rq.val;
                    sift_top_down();
                end else begin
                    heap_cnt--;
                    if (heap_cnt > 0) begin
                        heap_val[0] = heap_val[heap_cnt];
                        heap_lst[0] = heap_lst[heap_cnt];
                        sift_top_down();
                    end
                end
            end
            default: ;
        endcase
        rs.entries = 5'(heap_cnt);
        return rs;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3:    return 32'($urandom_range(0, 8)) - 32'd4;
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic offer(input logic [1:0] kind, input logic [3:0] list,
                         input logic [31:0] val, input logic more);
        t_merge_req item;
        item = '{kind, list, val, more};
        req_q.insert(req_q.size(), item);
        if (kind != REQ_NOP)
            queued++;
        if (kind == kwmh_pkg::REQ_INSERT && gen_cnt < HEAP_DEPTH)
            gen_cnt++;
        if (kind == kwmh_pkg::REQ_ADVANCE && !more && gen_cnt > 0)
            gen_cnt--;
    endtask

    // merge runs: load some heads, then report/advance until the heap drains; now and then one random request instead
    task automatic merge_sessions(input int target);
        int k;
        while (queued < target) begin
            if ($urandom_range(0, 9) == 0) begin
                offer(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), pick_value(),
                      1'($urandom_range(0, 1)));
            end else begin
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 8);
                repeat (k)
                    offer(kwmh_pkg::REQ_INSERT, 4'($urandom_range(0, 15)), pick_value(),
                          1'($urandom_range(0, 1)));
                while (gen_cnt > 0 && queued < target) begin
                    if ($urandom_range(0, 7) != 0)
                        offer(kwmh_pkg::REQ_REPORT, 4'($urandom_range(0, 15)), pick_value(),
                              1'($urandom_range(0, 1)));
                    offer(kwmh_pkg::REQ_ADVANCE, 4'($urandom_range(0, 15)), pick_value(),
                          $urandom_range(0, 3) != 0);
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || want_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic void flag(string name, logic [31:0] exp_v, logic [31:0] act_v);
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || took) begin
            took = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (req_q.size() == 0) begin
                i_s_axis_tvalid <= 1'b0;
            end else begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {3'b000, req_q[0].more, req_q[0].val, req_q[0].list};
                i_s_axis_tuser  <= req_q[0].kind;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 60);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                                           : $urandom_range(0, 2);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        rx_tick++;
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_SPARSE);
            rx_left = $urandom_range(16, 128);
        end else begin
            rx_left--;
        end
        // long hold-offs so the block backs up into its input
        if ((rx_tick >= 3000 && rx_tick < 3400) || (rx_tick >= 12000 && rx_tick < 12250))
            i_m_axis_tready <= 1'b0;
        else if (rx_mode == RX_OPEN)
            i_m_axis_tready <= 1'b1;
        else if (rx_mode == RX_HALF)
            i_m_axis_tready <= 1'($urandom_range(0, 1));
        else
            i_m_axis_tready <= ($urandom_range(0, 4) == 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            want_q.insert(want_q.size(), merge_apply(req_q.pop_front()));
            took = 1'b1;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{o_m_axis_tdata[31:0], o_m_axis_tdata[35:32], o_m_axis_tuser,
                    o_m_axis_tdata[40:36]};
            if (want_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, got);
            end else begin
                want = want_q.pop_front();
                if (got.min_val !== want.min_val)
                    flag("min_value", want.min_val, got.min_val);
                if (got.min_list !== want.min_list)
                    flag("min_list", 32'(want.min_list), 32'(got.min_list));
                if (got.status !== want.status)
                    flag("status", 32'(want.status), 32'(got.status));
                if (got.entries !== want.entries)
                    flag("entries", 32'(want.entries), 32'(got.entries));
            end
        end
    end

    initial begin
        offer(kwmh_pkg::REQ_REPORT, 4'h0, 32'h0, 1'b0);
        offer(kwmh_pkg::REQ_ADVANCE, 4'hf, 32'h7fff_ffff, 1'b1);
        offer(kwmh_pkg::REQ_ADVANCE, 4'h0, 32'h0, 1'b0);
        offer(REQ_NOP, 4'ha, 32'h1234_5678, 1'b1);
        offer(kwmh_pkg::REQ_INSERT, 4'hf, 32'h7fff_ffff, 1'b0);
        offer(kwmh_pkg::REQ_INSERT, 4'h0, 32'h8000_0000, 1'b1);
        offer(kwmh_pkg::REQ_INSERT, 4'h9, 32'hffff_ffff, 1'b0);
        offer(kwmh_pkg::REQ_INSERT, 4'h3, 32'hffff_ffff, 1'b0);
        offer(kwmh_pkg::REQ_INSERT, 4'h3, 32'hffff_ffff, 1'b0);
        offer(kwmh_pkg::REQ_REPORT, 4'h0, 32'h0, 1'b0);
        offer(kwmh_pkg::REQ_ADVANCE, 4'h0, 32'h7fff_ffff, 1'b1);
        offer(kwmh_pkg::REQ_REPORT, 4'h0, 32'h0, 1'b0);
        offer(kwmh_pkg::REQ_ADVANCE, 4'h0, 32'h0, 1'b0);
        offer(kwmh_pkg::REQ_REPORT, 4'h0, 32'h0, 1'b0);
        // fill to capacity, then one insert too many
        for (int j = 0; j < 13; j++)
            offer(kwmh_pkg::REQ_INSERT, 4'(j), 32'(j * 7) - 32'd40, 1'b0);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();
        merge_sessions(580);
        wait_drained();
        merge_sessions(1175);
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && want_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
